>>> sv/crcfc_pkg.sv
package crcfc_pkg;

    localparam int MEMORY_BYTES = 2048;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int MAX_RES = 3;

    localparam logic [6:0] DEV_BASE = 7'h50;
    localparam logic [15:0] POLY_RESET = 16'h1021;
    localparam logic [15:0] INIT_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BYTE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_CRC    = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_BOUNDS   = 2'd1,
        ERR_MISMATCH = 2'd2
    } err_t;

    typedef enum logic {
        REG_POLY = 1'b0,
        REG_INIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [6:0] device_address;
        err_t       error_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]             cnt;
        result_t [MAX_RES-1:0]  res;
    } push_t;

    typedef struct packed {
        logic space_ok;
    } q_status_t;

    function automatic result_t mk_res(kind_t k, logic [7:0] v, logic [6:0] d, err_t e,
                                       logic l);
        result_t r;
        r.kind = k;
        r.byte_value = v;
        r.device_address = d;
        r.error_code = e;
        r.last = l;
        return r;
    endfunction

    // MSB-first CRC-16, one byte, eight unrolled shift steps
    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [15:0] poly,
                                             logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> sv/crcfc_engine.sv
module crcfc_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [10:0]         address,
    input  logic [11:0]         record_length,
    input  logic                crc_on,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         crc_poly,
    input  logic [15:0]         crc_init,
    input  crcfc_pkg::q_status_t q_status,
    output crcfc_pkg::push_t    push
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WRITE  = 5'b00010,
        ST_RDATA  = 5'b00100,
        ST_CRC_HI = 5'b01000,
        ST_CRC_LO = 5'b10000
    } state_t;

    logic        in_vld_reg, in_vld_next;
    logic [1:0]  cmd_reg;
    logic [10:0] addr_reg;
    logic [11:0] len_reg;
    logic        crc_on_reg;
    logic [7:0]  data_reg;

    state_t      state_reg, state_next;
    logic [15:0] crc_reg, crc_next;
    logic [11:0] left_reg, left_next;
    logic        crc_en_reg, crc_en_next;
    logic [7:0]  rx_hi_reg, rx_hi_next;

    logic        take;
    logic        accept;
    logic [12:0] end_addr;
    logic [7:0]  offset;
    logic [6:0]  dev;
    logic [15:0] crc_fed;
    logic [11:0] left_dec;

    assign take     = in_vld_reg && q_status.space_ok;
    assign in_stall = in_vld_reg && !q_status.space_ok;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (take)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            addr_reg   <= address;
            len_reg    <= record_length;
            crc_on_reg <= crc_on;
            data_reg   <= data_byte;
        end
    end

    assign end_addr = {2'b00, addr_reg} + {1'b0, len_reg};
    assign offset   = addr_reg[7:0];
    assign dev      = crcfc_pkg::DEV_BASE | {4'b0000, addr_reg[10:8]};
    assign crc_fed  = crcfc_pkg::crc_feed(crc_reg, crc_poly, data_reg);
    assign left_dec = left_reg - 12'd1;

    always_comb
    begin
        state_next  = state_reg;
        crc_next    = crc_reg;
        left_next   = left_reg;
        crc_en_next = crc_en_reg;
        rx_hi_next  = rx_hi_reg;
        push        = '0;
        if (take)
        begin
            case (cmd_reg) inside
                crcfc_pkg::CMD_WRITE, crcfc_pkg::CMD_READ:
                begin
                    state_next = ST_IDLE;
                    push.cnt   = 2'd1;
                    if (end_addr > 13'(crcfc_pkg::MEMORY_BYTES))
                    begin
                        push.res[0] = crcfc_pkg::mk_res(crcfc_pkg::KIND_HEADER, offset, dev,
                                                        crcfc_pkg::ERR_BOUNDS, 1'b1);
                    end
                    else
                    begin
                        crc_next    = crc_init;
                        left_next   = len_reg;
                        crc_en_next = crc_on_reg;
                        push.res[0] = crcfc_pkg::mk_res(crcfc_pkg::KIND_HEADER, offset, dev,
                                                        crcfc_pkg::ERR_OK,
                                                        (len_reg == 12'd0) && !crc_on_reg);
                        if (len_reg == 12'd0)
                        begin
                            if (crc_on_reg)
                            begin
                                if (cmd_reg == crcfc_pkg::CMD_WRITE)
                                begin
                                    // empty write: CRC of no data straight away
                                    push.cnt    = 2'd3;
                                    push.res[1] = crcfc_pkg::mk_res(crcfc_pkg::KIND_CRC,
                                                                    crc_init[15:8], 7'd0,
                                                                    crcfc_pkg::ERR_OK, 1'b0);
                                    push.res[2] = crcfc_pkg::mk_res(crcfc_pkg::KIND_CRC,
                                                                    crc_init[7:0], 7'd0,
                                                                    crcfc_pkg::ERR_OK, 1'b1);
                                end
                                else
                                    state_next = ST_CRC_HI;
                            end
                        end
                        else if (cmd_reg == crcfc_pkg::CMD_WRITE)
                            state_next = ST_WRITE;
                        else
                            state_next = ST_RDATA;
                    end
                end
                crcfc_pkg::CMD_BYTE:
                begin
                    unique case (state_reg) inside
                        ST_IDLE:
                        begin
                        end
                        ST_CRC_HI:
                        begin
                            rx_hi_next = data_reg;
                            state_next = ST_CRC_LO;
                        end
                        ST_CRC_LO:
                        begin
                            push.cnt    = 2'd1;
                            push.res[0] = crcfc_pkg::mk_res(crcfc_pkg::KIND_STATUS, 8'd0, 7'd0,
                                              ({rx_hi_reg, data_reg} == crc_reg) ?
                                              crcfc_pkg::ERR_OK : crcfc_pkg::ERR_MISMATCH,
                                              1'b1);
                            state_next  = ST_IDLE;
                        end
                        ST_WRITE, ST_RDATA:
                        begin
                            crc_next    = crc_fed;
                            left_next   = left_dec;
                            push.cnt    = 2'd1;
                            push.res[0] = crcfc_pkg::mk_res(crcfc_pkg::KIND_DATA, data_reg, 7'd0,
                                              crcfc_pkg::ERR_OK,
                                              (left_dec == 12'd0) && !crc_en_reg);
                            if (left_dec == 12'd0)
                            begin
                                if (!crc_en_reg)
                                    state_next = ST_IDLE;
                                else if (state_reg == ST_WRITE)
                                begin
                                    push.cnt    = 2'd3;
                                    push.res[1] = crcfc_pkg::mk_res(crcfc_pkg::KIND_CRC,
                                                                    crc_fed[15:8], 7'd0,
                                                                    crcfc_pkg::ERR_OK, 1'b0);
                                    push.res[2] = crcfc_pkg::mk_res(crcfc_pkg::KIND_CRC,
                                                                    crc_fed[7:0], 7'd0,
                                                                    crcfc_pkg::ERR_OK, 1'b1);
                                    state_next  = ST_IDLE;
                                end
                                else
                                    state_next = ST_CRC_HI;
                            end
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            crc_reg    <= crcfc_pkg::INIT_RESET;
            left_reg   <= 12'd0;
            crc_en_reg <= 1'b0;
            rx_hi_reg  <= 8'd0;
        end
        else
        begin
            state_reg  <= state_next;
            crc_reg    <= crc_next;
            left_reg   <= left_next;
            crc_en_reg <= crc_en_next;
            rx_hi_reg  <= rx_hi_next;
        end
    end

endmodule

>>> sv/crcfc_resq.sv
module crcfc_resq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crcfc_pkg::push_t     push,
    output crcfc_pkg::q_status_t q_status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output crcfc_pkg::result_t   head
);

    crcfc_pkg::result_t q_reg [crcfc_pkg::QDEPTH];

    logic [crcfc_pkg::QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [crcfc_pkg::QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [crcfc_pkg::QAW:0]   count_reg, count_next;
    logic                      pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = q_reg[rd_ptr_reg];

    // room for the largest burst one request can cause
    assign q_status.space_ok =
        (count_reg <= (crcfc_pkg::QAW+1)'(crcfc_pkg::QDEPTH - crcfc_pkg::MAX_RES));

    assign wr_ptr_next = wr_ptr_reg + crcfc_pkg::QAW'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + crcfc_pkg::QAW'(pop);
    assign count_next  = count_reg + (crcfc_pkg::QAW+1)'(push.cnt)
                                   - (crcfc_pkg::QAW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < crcfc_pkg::MAX_RES; i++)
        begin
            if (i < int'(push.cnt))
                q_reg[crcfc_pkg::QAW'(int'(wr_ptr_reg) + i)] <= push.res[i];
        end
    end

endmodule

>>> sv/crc16_record_framer_checker_core.sv
// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pready  paddr, pwdata, prdata (poly at 0, init at 4)
// request   in         in_valid/in_stall    command, address, record_length, crc_on, data_byte
// result    out        out_valid/out_stall  kind, byte_value, device_address, error_code, last
//
// A request is held in the input register and worked from there, one request per cycle
// while in_stall is low. Each request yields up to three results into a four-entry result
// queue; in_stall rises while more than one result is queued, as a held request might not fit.
// A write's last byte with CRC on gives three results, drained at one per cycle while out_stall
// is low, so the next request waits until no more than one result is left.
// Reset clears the record state and the queue; no clearing pass.
module crc16_record_framer_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [10:0] address,
    input  logic [11:0] record_length,
    input  logic        crc_on,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  byte_value,
    output logic [6:0]  device_address,
    output logic [1:0]  error_code,
    output logic        last
);

    logic [15:0] poly_reg, poly_next;
    logic [15:0] init_reg, init_next;
    logic        wr_en;

    crcfc_pkg::push_t     push;
    crcfc_pkg::q_status_t q_status;
    crcfc_pkg::result_t   head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        poly_next = poly_reg;
        init_next = init_reg;
        if (wr_en)
        begin
            unique case (crcfc_pkg::reg_idx_t'(paddr[2]))
                crcfc_pkg::REG_POLY: poly_next = pwdata[15:0];
                crcfc_pkg::REG_INIT: init_next = pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= crcfc_pkg::POLY_RESET;
            init_reg <= crcfc_pkg::INIT_RESET;
        end
        else
        begin
            poly_reg <= poly_next;
            init_reg <= init_next;
        end
    end

    assign prdata = (crcfc_pkg::reg_idx_t'(paddr[2]) == crcfc_pkg::REG_INIT) ?
                    {16'd0, init_reg} : {16'd0, poly_reg};

    crcfc_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .address       (address),
        .record_length (record_length),
        .crc_on        (crc_on),
        .data_byte     (data_byte),
        .crc_poly      (poly_reg),
        .crc_init      (init_reg),
        .q_status      (q_status),
        .push          (push)
    );

    crcfc_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_status  (q_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind           = head.kind;
    assign byte_value     = head.byte_value;
    assign device_address = head.device_address;
    assign error_code     = head.error_code;
    assign last           = head.last;

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == crcfc_pkg::KIND_STATUS) |-> last)
        else $error("status result without last");

    a_bounds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == crcfc_pkg::KIND_HEADER && error_code == crcfc_pkg::ERR_BOUNDS)
        |-> last)
        else $error("rejected header without last");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> q_status.space_ok)
        else $error("results pushed into a full queue");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !q_status.space_ok) |=> in_stall || q_status.space_ok)
        else $error("held request lost");

endmodule
